FILE: sv/fdts_pkg.sv
// Package for the fan duty and tach speed block: register indexes,
// pipeline stage map, arithmetic constants and the pipeline item record.
// No dependencies.
package fdts_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_LOW     = 3'd0;
  localparam logic [2:0] REG_TEMP_HIGH    = 3'd1;
  localparam logic [2:0] REG_DUTY_LOW     = 3'd2;
  localparam logic [2:0] REG_DUTY_HIGH    = 3'd3;
  localparam logic [2:0] REG_PWM_TOP      = 3'd4;
  localparam logic [2:0] REG_CAPTURE_WRAP = 3'd5;
  localparam logic [2:0] REG_TICKS_PER_US = 3'd6;

  // Register reset values
  localparam logic signed [14:0] RST_TEMP_LOW     = 15'sd3000;
  localparam logic signed [14:0] RST_TEMP_HIGH    = 15'sd7000;
  localparam logic [6:0]         RST_DUTY_LOW     = 7'd30;
  localparam logic [6:0]         RST_DUTY_HIGH    = 7'd100;
  localparam logic [15:0]        RST_PWM_TOP      = 16'd999;
  localparam logic [15:0]        RST_CAPTURE_WRAP = 16'd65535;
  localparam logic [7:0]         RST_TICKS_PER_US = 8'd1;

  // Arithmetic widths and constants
  localparam int DUTY_QBITS = 7;   // curve quotient stays below 128
  localparam int TICK_BITS  = 26;  // both phases at worst case
  localparam int RPM_QBITS  = 16;  // non-saturated rpm quotient
  localparam logic [24:0] RPM_NUM     = 25'd30000000;  // 60 s in us over 2 pulses
  localparam logic [25:0] RPM_SAT_US  = 26'd458;       // below this rpm exceeds 16 bits
  localparam logic [23:0] RECIP_100   = 24'd10737419;  // ceil(2^30 / 100)
  localparam int          RECIP_SHIFT = 30;

  // Stage map
  localparam int S_IN    = 0;
  localparam int S_PREP  = 1;
  localparam int T_FIRST = 2;                        // tick / ticks_per_us steps
  localparam int S_DMUL  = 2;
  localparam int D_FIRST = 3;                        // curve division steps
  localparam int S_DUTY  = D_FIRST + DUTY_QBITS;
  localparam int S_CMUL  = S_DUTY + 1;
  localparam int S_CDIV  = S_CMUL + 1;
  localparam int S_US    = T_FIRST + TICK_BITS;
  localparam int R_FIRST = S_US + 1;                 // rpm division steps
  localparam int S_RPM   = R_FIRST + RPM_QBITS;
  localparam int N_STAGES = S_RPM + 1;

  typedef struct packed {
    logic signed [14:0] temp;
    logic               cap;
    logic [7:0]         hw;
    logic [15:0]        hr;
    logic [7:0]         lw;
    logic [15:0]        lr;
    logic               lo_hit;
    logic               hi_hit;
    logic               dneg;
    logic [15:0]        dspan;
    logic [15:0]        ddiff;
    logic [6:0]         dmul;
    logic [22:0]        drem;
    logic [6:0]         dq;
    logic [6:0]         duty;
    logic [22:0]        cmpx;
    logic [15:0]        cmp;
    logic [25:0]        trem;
    logic [25:0]        tq;
    logic               rzero;
    logic               rsat;
    logic [24:0]        rrem;
    logic [15:0]        rq;
    logic [15:0]        rpm;
  } item_t;

endpackage

FILE: sv/fan_duty_and_tach_speed.sv
// Fan duty and tach speed: top level, one fully pipelined datapath.
// Depends on fdts_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one fan channel reading per
//    item: temperature in centidegrees and the tach capture (wraps and
//    residual counts of the high and low phases, capture_done flag).
//  - Result channel (out_valid / out_stall) returns one item per input:
//    duty percent from the fan curve, PWM compare value and fan speed in rpm.
//  - Configuration port (cfg_we / cfg_index / cfg_data) writes the curve,
//    PWM and capture timer registers; write only while no item is in flight.
//  - One item may enter every cycle while the result is not stalled, as every
//    stage is registered. The pipeline has 46 stages, whose long part is a
//    bit-per-stage divide of ticks by ticks_per_us (26 stages) followed by a
//    bit-per-stage divide of 30000000 by the period (16 stages).
//  - When the receiver stalls a valid result, the whole pipeline holds and
//    in_stall is raised; nothing is dropped or repeated.
//  - Synchronous reset empties the pipeline and loads register defaults.
module fan_duty_and_tach_speed (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] in_temp_centi,
  input  logic               in_capture_done,
  input  logic [7:0]         in_high_wraps,
  input  logic [15:0]        in_high_residual,
  input  logic [7:0]         in_low_wraps,
  input  logic [15:0]        in_low_residual,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_duty_percent,
  output logic [15:0]        out_compare_value,
  output logic [15:0]        out_fan_rpm,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import fdts_pkg::*;

  logic signed [14:0] temp_low_r, temp_high_r;
  logic [6:0]         duty_low_r, duty_high_r;
  logic [15:0]        pwm_top_r, capture_wrap_r;
  logic [7:0]         ticks_per_us_r;

  logic               vld_r [N_STAGES];
  item_t              pl_r  [N_STAGES];
  item_t              pl_nxt[N_STAGES];
  logic               adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_low_r     <= RST_TEMP_LOW;
      temp_high_r    <= RST_TEMP_HIGH;
      duty_low_r     <= RST_DUTY_LOW;
      duty_high_r    <= RST_DUTY_HIGH;
      pwm_top_r      <= RST_PWM_TOP;
      capture_wrap_r <= RST_CAPTURE_WRAP;
      ticks_per_us_r <= RST_TICKS_PER_US;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_LOW:     temp_low_r     <= cfg_data[14:0];
        REG_TEMP_HIGH:    temp_high_r    <= cfg_data[14:0];
        REG_DUTY_LOW:     duty_low_r     <= cfg_data[6:0];
        REG_DUTY_HIGH:    duty_high_r    <= cfg_data[6:0];
        REG_PWM_TOP:      pwm_top_r      <= cfg_data;
        REG_CAPTURE_WRAP: capture_wrap_r <= cfg_data;
        REG_TICKS_PER_US: ticks_per_us_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Hold every stage while the result is stalled
  assign adv      = !(vld_r[N_STAGES-1] && out_stall);
  assign in_stall = !adv;

  // Per-stage work
  always_comb begin
    logic signed [15:0] diff, span;
    logic signed [7:0]  dd;
    logic [8:0]         wsum;
    logic [24:0]        wprod;
    logic [22:0]        dden;
    logic [33:0]        tden;
    logic [41:0]        rden;
    logic signed [9:0]  dval;
    logic signed [9:0]  sq;
    logic [46:0]        cprod;
    logic [16:0]        cq;
    int                 b;

    pl_nxt[S_IN]       = '0;
    pl_nxt[S_IN].temp  = in_temp_centi;
    pl_nxt[S_IN].cap   = in_capture_done;
    pl_nxt[S_IN].hw    = in_high_wraps;
    pl_nxt[S_IN].hr    = in_high_residual;
    pl_nxt[S_IN].lw    = in_low_wraps;
    pl_nxt[S_IN].lr    = in_low_residual;

    for (int s = 1; s < N_STAGES; s++) begin
      pl_nxt[s] = pl_r[s-1];

      // Curve tests, offsets and tick total
      if (s == S_PREP) begin
        diff = {pl_r[s-1].temp[14], pl_r[s-1].temp} - {temp_low_r[14], temp_low_r};
        span = {temp_high_r[14], temp_high_r} - {temp_low_r[14], temp_low_r};
        pl_nxt[s].lo_hit = (pl_r[s-1].temp <= temp_low_r);
        pl_nxt[s].hi_hit = (pl_r[s-1].temp >= temp_high_r);
        pl_nxt[s].ddiff  = diff;
        pl_nxt[s].dspan  = span;
        dd = $signed({1'b0, duty_high_r}) - $signed({1'b0, duty_low_r});
        pl_nxt[s].dneg = dd[7];
        pl_nxt[s].dmul = dd[7] ? 7'(-dd) : dd[6:0];
        wsum  = {1'b0, pl_r[s-1].hw} + {1'b0, pl_r[s-1].lw};
        wprod = 25'(wsum) * 25'(capture_wrap_r);
        pl_nxt[s].trem = 26'(wprod) + 26'(pl_r[s-1].hr) + 26'(pl_r[s-1].lr);
        pl_nxt[s].tq   = '0;
      end

      // Curve numerator magnitude
      if (s == S_DMUL) begin
        pl_nxt[s].drem = 23'(pl_r[s-1].ddiff) * 23'(pl_r[s-1].dmul);
        pl_nxt[s].dq   = '0;
      end

      // Curve division, one quotient bit a stage
      if (s >= D_FIRST && s < D_FIRST + DUTY_QBITS) begin
        b    = D_FIRST + DUTY_QBITS - 1 - s;
        dden = 23'(pl_r[s-1].dspan) << b;
        if (pl_r[s-1].drem >= dden) begin
          pl_nxt[s].drem = pl_r[s-1].drem - dden;
          pl_nxt[s].dq   = pl_r[s-1].dq | 7'(7'd1 << b);
        end
      end

      // Apply sign, clamp and pick the curve branch
      if (s == S_DUTY) begin
        sq   = pl_r[s-1].dneg ? -$signed({3'b0, pl_r[s-1].dq})
                              :  $signed({3'b0, pl_r[s-1].dq});
        dval = $signed({3'b0, duty_low_r}) + sq;
        if (pl_r[s-1].lo_hit)       pl_nxt[s].duty = duty_low_r;
        else if (pl_r[s-1].hi_hit)  pl_nxt[s].duty = duty_high_r;
        else if (dval < 0)          pl_nxt[s].duty = '0;
        else if (dval > 10'sd127)   pl_nxt[s].duty = 7'd127;
        else                        pl_nxt[s].duty = dval[6:0];
      end

      if (s == S_CMUL) begin
        pl_nxt[s].cmpx = 23'(pl_r[s-1].duty) * 23'(pwm_top_r);
      end

      // Divide by 100 through the reciprocal, saturate
      if (s == S_CDIV) begin
        cprod = 47'(pl_r[s-1].cmpx) * 47'(RECIP_100);
        cq    = cprod[RECIP_SHIFT +: 17];
        pl_nxt[s].cmp = cq[16] ? 16'hFFFF : cq[15:0];
      end

      // Ticks to microseconds, one quotient bit a stage
      if (s >= T_FIRST && s < T_FIRST + TICK_BITS) begin
        b    = T_FIRST + TICK_BITS - 1 - s;
        tden = 34'(ticks_per_us_r) << b;
        if (34'(pl_r[s-1].trem) >= tden) begin
          pl_nxt[s].trem = pl_r[s-1].trem - tden[25:0];
          pl_nxt[s].tq   = pl_r[s-1].tq | 26'(26'd1 << b);
        end
      end

      // Special cases of the speed
      if (s == S_US) begin
        pl_nxt[s].rzero = !pl_r[s-1].cap || (ticks_per_us_r == '0) ||
                          (pl_r[s-1].tq == '0);
        pl_nxt[s].rsat  = (pl_r[s-1].tq < RPM_SAT_US);
        pl_nxt[s].rrem  = RPM_NUM;
        pl_nxt[s].rq    = '0;
      end

      // Rpm division, one quotient bit a stage
      if (s >= R_FIRST && s < R_FIRST + RPM_QBITS) begin
        b    = R_FIRST + RPM_QBITS - 1 - s;
        rden = 42'(pl_r[s-1].tq) << b;
        if (42'(pl_r[s-1].rrem) >= rden) begin
          pl_nxt[s].rrem = pl_r[s-1].rrem - rden[24:0];
          pl_nxt[s].rq   = pl_r[s-1].rq | 16'(16'd1 << b);
        end
      end

      if (s == S_RPM) begin
        if (pl_r[s-1].rzero)     pl_nxt[s].rpm = '0;
        else if (pl_r[s-1].rsat) pl_nxt[s].rpm = 16'hFFFF;
        else                     pl_nxt[s].rpm = pl_r[s-1].rq;
      end
    end
  end

  // Advance payload and valid bits together
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < N_STAGES; s++) begin
        pl_r[s] <= pl_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < N_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[S_IN] <= in_valid;
      for (int s = 1; s < N_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign out_valid         = vld_r[N_STAGES-1];
  assign out_duty_percent  = pl_r[N_STAGES-1].duty;
  assign out_compare_value = pl_r[N_STAGES-1].cmp;
  assign out_fan_rpm       = pl_r[N_STAGES-1].rpm;

endmodule

FILE: sv/fdts_chk.sv
// Port checker for the fan duty and tach speed block, with its bind.
// Depends on fan_duty_and_tach_speed ports only.
module fdts_chk (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stall the input only behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Drop every item at reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind fan_duty_and_tach_speed fdts_chk u_fdts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
